@@ hw/rtl/ebml_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML header encoder package
// Shared widths, constants and the header record handed to the serializer.
// ----------------------------------------------------------------------------
package ebml_pkg;

	localparam int ID_W       = 32;
	localparam int SIZE_W     = 56;
	localparam int FLEN_W     = 4;
	localparam int GROUP_BITS = 7;
	localparam int MAX_BYTES  = 8;
	localparam int VINT_W     = 64;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [VINT_W-1:0] vint;
		logic [2:0]        idn;
		logic [3:0]        len;
		logic [3:0]        total;
		logic              ovf;
	} hdr_t;

endpackage

@@ hw/rtl/ebml_hdr_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element header request channel
// Valid/ready channel carrying element ID, data size and forced length.
// ----------------------------------------------------------------------------
interface ebml_hdr_in_if;
	logic                            valid;
	logic                            ready;
	logic [ebml_pkg::ID_W-1:0]       element_id;
	logic [ebml_pkg::SIZE_W-1:0]     data_size;
	logic [ebml_pkg::FLEN_W-1:0]     forced_length;

	modport source (output valid, element_id, data_size, forced_length, input ready);
	modport sink   (input valid, element_id, data_size, forced_length, output ready);
endinterface

@@ hw/rtl/ebml_byte_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header byte channel
// Valid/ready channel carrying one encoded header byte per transfer.
// ----------------------------------------------------------------------------
interface ebml_byte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic [3:0] header_length;
	logic       size_overflow;

	modport source (output valid, out_byte, last_byte, header_length, size_overflow,
		input ready);
	modport sink   (input valid, out_byte, last_byte, header_length, size_overflow,
		output ready);
endinterface

@@ hw/rtl/ebml_ser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML header serializer
// Holds one encoded header and sends it one byte per transfer, ID first.
// ----------------------------------------------------------------------------
module ebml_ser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hdr_valid,
	input  ebml_pkg::hdr_t        hdr,
	output logic                  hdr_take,
	ebml_byte_out_if.source       result
);

	logic           busy_q;
	logic [3:0]     k_q;
	ebml_pkg::hdr_t h_q;

	logic       last;
	logic       xfer;
	logic       is_id;
	logic [3:0] id_ix;
	logic [3:0] v_ix;

	always_comb begin
		last     = (k_q + 4'd1) == h_q.total;
		xfer     = busy_q && result.ready;
		hdr_take = !busy_q || (xfer && last);
		is_id    = k_q < {1'b0, h_q.idn};
		id_ix    = {1'b0, h_q.idn} - 4'd1 - k_q;
		v_ix     = h_q.total - 4'd1 - k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= 4'd0;
		end else if (hdr_take) begin
			busy_q <= hdr_valid;
			k_q    <= 4'd0;
		end else if (xfer) begin
			k_q <= k_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_take && hdr_valid) begin
			h_q <= hdr;
		end
	end

	always_comb begin
		result.valid         = busy_q;
		result.last_byte     = last;
		result.header_length = h_q.total;
		result.size_overflow = h_q.ovf;
		if (is_id) begin
			result.out_byte = h_q.id[8*id_ix[1:0] +: 8];
		end else begin
			result.out_byte = h_q.vint[8*v_ix[2:0] +: 8];
		end
	end

endmodule

@@ hw/rtl/ebml_element_header_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML element header encoder
// Turns an element ID and data size into the byte stream of its header.
// ----------------------------------------------------------------------------
// A request passes three register stages (input capture, size+1 and ID byte
// count, vint length and marker) and then a serializer that sends the header
// one byte per cycle while the byte channel is ready: a header of N bytes (2 to
// 12, ID bytes plus size length) holds the byte-wide output until its last
// byte is taken, and the next header is loaded at the same edge as that last
// byte. A request is registered in the capture, size+1 and encoded-header
// stages and then in the serializer. A forced length of zero picks the
// shortest size field, lengths above eight count as eight, and size_overflow
// is flagged on every byte when the size does not fit the chosen length.
module ebml_element_header_encoder (
	input  logic             clk,
	input  logic             arst_n,
	ebml_hdr_in_if.sink      item,
	ebml_byte_out_if.source  result
);

	// stage 1: capture
	logic                            v_s1;
	logic [ebml_pkg::ID_W-1:0]       id_s1;
	logic [ebml_pkg::SIZE_W-1:0]     size_s1;
	logic [ebml_pkg::FLEN_W-1:0]     flen_s1;

	// stage 2: size+1, ID byte count
	logic                            v_s2;
	logic [ebml_pkg::ID_W-1:0]       id_s2;
	logic [ebml_pkg::SIZE_W-1:0]     size_s2;
	logic [ebml_pkg::SIZE_W:0]       sizep1_s2;
	logic [2:0]                      idn_s2;
	logic [ebml_pkg::FLEN_W-1:0]     flen_s2;

	// stage 3: encoded header
	logic                            v_s3;
	ebml_pkg::hdr_t                  hdr_s3;

	logic       rdy1, rdy2, rdy3;
	logic       take;
	logic [2:0] idn_c;
	logic [3:0] need;
	logic [3:0] flen_c;
	logic [3:0] len_c;
	ebml_pkg::hdr_t hdr_c;

	assign rdy3       = !v_s3 || take;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign item.ready = rdy1;

	always_comb begin
		if (id_s1[31:24] != 8'd0) begin
			idn_c = 3'd4;
		end else if (id_s1[23:16] != 8'd0) begin
			idn_c = 3'd3;
		end else if (id_s1[15:8] != 8'd0) begin
			idn_c = 3'd2;
		end else begin
			idn_c = 3'd1;
		end
	end

	always_comb begin
		need = 4'd1;
		for (int n = 1; n <= ebml_pkg::MAX_BYTES; n++) begin
			if ((sizep1_s2 >> (ebml_pkg::GROUP_BITS * n)) != '0) begin
				need = 4'(n + 1);
			end
		end
		flen_c = (flen_s2 == 4'd0) ? need : flen_s2;
		len_c  = (flen_c > 4'(ebml_pkg::MAX_BYTES)) ? 4'(ebml_pkg::MAX_BYTES) : flen_c;
		hdr_c.id    = id_s2;
		hdr_c.vint  = {{(ebml_pkg::VINT_W-ebml_pkg::SIZE_W){1'b0}}, size_s2}
			| (64'd1 << (ebml_pkg::GROUP_BITS * len_c));
		hdr_c.idn   = idn_s2;
		hdr_c.len   = len_c;
		hdr_c.total = {1'b0, idn_s2} + len_c;
		hdr_c.ovf   = need > len_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && item.valid) begin
			id_s1   <= item.element_id;
			size_s1 <= item.data_size;
			flen_s1 <= item.forced_length;
		end
		if (rdy2 && v_s1) begin
			id_s2     <= id_s1;
			size_s2   <= size_s1;
			sizep1_s2 <= {1'b0, size_s1} + 57'd1;
			idn_s2    <= idn_c;
			flen_s2   <= flen_s1;
		end
		if (rdy3 && v_s2) begin
			hdr_s3 <= hdr_c;
		end
	end

	ebml_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (v_s3),
		.hdr       (hdr_s3),
		.hdr_take  (take),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_hdr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (hdr_s3.len >= 4'd1 && hdr_s3.len <= 4'd8
			&& hdr_s3.total == {1'b0, hdr_s3.idn} + hdr_s3.len))
		else $error("encoded header length inconsistent");
	a_out_len: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.header_length >= 4'd2 && result.header_length <= 4'd12))
		else $error("header length out of range");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (v_s1 && v_s2 && v_s3 && !take))
		else $error("input stalled with room in the pipeline");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && take) |=> result.valid)
		else $error("header taken but no byte presented");
`endif

endmodule
